FILE: design/group_membership_table_unit_macros.svh
// ----------------------------------------------------------------------------
// Group membership table assertion macros
// Shorthand for clocked, reset-qualified implication properties.
// ----------------------------------------------------------------------------
`ifndef GROUP_MEMBERSHIP_TABLE_UNIT_MACROS_SVH
`define GROUP_MEMBERSHIP_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define GMT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define GMT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/gmt_pkg.sv
// ----------------------------------------------------------------------------
// Group membership table package
// Widths, codes and the types shared by the slot cells, the row and the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gmt_pkg;

    localparam int SLOTS       = 16;
    localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int ADDR_W      = 32;
    localparam int CNT_W       = 5;
    localparam int MODE_W      = 2;
    localparam int STATUS_W    = 3;
    localparam int SLOT_FLD_W  = 4;
    localparam int OCC_W       = $clog2(SLOTS + 1);

    // Width that holds both a slot index plus one and a configured limit.
    localparam int CMP_W = ((SLOT_W + 1) > CNT_W) ? (SLOT_W + 1) : CNT_W;
    // Width that holds both the member count and an occupancy tally.
    localparam int SUB_W = (OCC_W > CNT_W) ? OCC_W : CNT_W;

    localparam int OUT_FLD_W  = STATUS_W + SLOT_FLD_W + ADDR_W + CNT_W;
    localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W  = OUT_DATA_W - OUT_FLD_W;

    localparam int OUT_STATUS_LSB = 0;
    localparam int OUT_SLOT_LSB   = OUT_STATUS_LSB + STATUS_W;
    localparam int OUT_ADDR_LSB   = OUT_SLOT_LSB + SLOT_FLD_W;
    localparam int OUT_COUNT_LSB  = OUT_ADDR_LSB + ADDR_W;

    localparam logic [CNT_W-1:0] LIMIT_RST = CNT_W'(16);

    typedef enum logic [MODE_W-1:0] {
        MODE_JOIN  = 2'd0,
        MODE_QUIT  = 2'd1,
        MODE_LIST  = 2'd2,
        MODE_CLEAR = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_JOINED  = 3'd0,
        ST_FULL    = 3'd1,
        ST_DUP     = 3'd2,
        ST_REMOVED = 3'd3,
        ST_NOTMEM  = 3'd4,
        ST_LISTED  = 3'd5,
        ST_EMPTY   = 3'd6
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_COUNT,
        S_REST,
        S_SCAN
    } t_state;

    // Commands from the sequencer to the row of slot cells.
    typedef struct packed {
        logic [ADDR_W-1:0] key;
        logic [CNT_W-1:0]  limit;
        logic              join_we;
        logic              quit_kill;
        logic              shift;
        logic              start;
        logic              flush;
        logic              clear_scan;
    } t_row_cmd;

    // Status from the row of slot cells back to the sequencer.
    typedef struct packed {
        logic              any_hit;
        logic [SLOT_W-1:0] hit_idx;
        logic              any_free;
        logic [SLOT_W-1:0] free_idx;
        logic              any_occ;
        logic              tok_occ;
        logic              tok_last;
        logic [SLOT_W-1:0] tok_idx;
        logic [ADDR_W-1:0] tok_addr;
    } t_row_stat;

endpackage

`default_nettype wire

FILE: design/gmt_cell.sv
// ----------------------------------------------------------------------------
// Group membership table slot cell
// Holds one slot's valid flag and address, and one stage of the scan token.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gmt_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [gmt_pkg::ADDR_W-1:0] i_key,
    input  logic                      i_in_use,
    input  logic                      i_set,
    input  logic                      i_kill,
    input  logic                      i_shift,
    input  logic                      i_flush,
    input  logic                      i_tok,
    input  logic                      i_rest,
    output logic                      o_hit,
    output logic                      o_free,
    output logic                      o_occ,
    output logic                      o_tok,
    output logic                      o_rest,
    output logic                      o_last,
    output logic [gmt_pkg::ADDR_W-1:0] o_tok_addr
);
    import gmt_pkg::*;

    logic              r_valid;
    logic              r_tok;
    logic [ADDR_W-1:0] r_addr;
    logic              occ;

    assign occ        = r_valid & i_in_use;
    assign o_occ      = occ;
    assign o_hit      = occ & (r_addr == i_key);
    assign o_free     = i_in_use & ~r_valid;
    assign o_tok      = r_tok;
    // Occupied slots at or above this one, passed down the chain.
    assign o_rest     = occ | i_rest;
    assign o_last     = r_tok & occ & ~i_rest;
    assign o_tok_addr = (r_tok & occ) ? r_addr : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tok   <= 1'b0;
        end else begin
            if (i_set) begin
                r_valid <= 1'b1;
            end else if (i_kill) begin
                r_valid <= 1'b0;
            end
            if (i_flush) begin
                r_tok <= 1'b0;
            end else if (i_shift) begin
                r_tok <= i_tok;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_set) begin
            r_addr <= i_key;
        end
    end

endmodule

`default_nettype wire

FILE: design/gmt_row.sv
// ----------------------------------------------------------------------------
// Group membership table cell row
// Chains the slot cells and picks the first hit, first free slot and token.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gmt_row (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gmt_pkg::t_row_cmd  i_cmd,
    output gmt_pkg::t_row_stat o_stat
);
    import gmt_pkg::*;

    logic [SLOTS-1:0]  hit;
    logic [SLOTS-1:0]  free;
    logic [SLOTS-1:0]  occ;
    logic [SLOTS-1:0]  tok;
    logic [SLOTS-1:0]  last;
    logic [SLOTS-1:0]  set;
    logic [SLOTS-1:0]  kill;
    logic [SLOTS:0]    rest_chain;
    logic [SLOTS-1:0]  hit_oh;
    logic [SLOTS-1:0]  free_oh;
    logic [ADDR_W-1:0] tok_addr [SLOTS];

    // Lowest set bit of each request vector.
    assign hit_oh  = hit & (~hit + SLOTS'(1));
    assign free_oh = free & (~free + SLOTS'(1));

    assign rest_chain[SLOTS] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < SLOTS; g++) begin : g_cell
            logic in_use;
            logic tok_in;

            assign in_use = (CMP_W'(g) < CMP_W'(i_cmd.limit));
            if (g == 0) begin : g_head
                assign tok_in = i_cmd.start;
            end else begin : g_body
                assign tok_in = tok[g-1];
            end
            assign set[g]  = i_cmd.join_we & free_oh[g];
            assign kill[g] = (i_cmd.quit_kill & hit_oh[g])
                           | (i_cmd.clear_scan & i_cmd.shift & tok[g] & occ[g]);

            gmt_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_key      (i_cmd.key),
                .i_in_use   (in_use),
                .i_set      (set[g]),
                .i_kill     (kill[g]),
                .i_shift    (i_cmd.shift),
                .i_flush    (i_cmd.flush),
                .i_tok      (tok_in),
                .i_rest     (rest_chain[g+1]),
                .o_hit      (hit[g]),
                .o_free     (free[g]),
                .o_occ      (occ[g]),
                .o_tok      (tok[g]),
                .o_rest     (rest_chain[g]),
                .o_last     (last[g]),
                .o_tok_addr (tok_addr[g])
            );
        end
    endgenerate

    always_comb begin
        o_stat          = '0;
        o_stat.any_hit  = |hit;
        o_stat.any_free = |free;
        o_stat.any_occ  = rest_chain[0];
        o_stat.tok_occ  = |(tok & occ);
        o_stat.tok_last = |last;
        for (int i = 0; i < SLOTS; i++) begin
            if (hit_oh[i]) begin
                o_stat.hit_idx = o_stat.hit_idx | SLOT_W'(i);
            end
            if (free_oh[i]) begin
                o_stat.free_idx = o_stat.free_idx | SLOT_W'(i);
            end
            if (tok[i]) begin
                o_stat.tok_idx = o_stat.tok_idx | SLOT_W'(i);
            end
            o_stat.tok_addr = o_stat.tok_addr | tok_addr[i];
        end
    end

endmodule

`default_nettype wire

FILE: design/group_membership_table_unit.sv
// ----------------------------------------------------------------------------
// Group membership table unit
// Slot table of group members keyed by a 32-bit address, with join, quit,
// broadcast listing and clear-all requests.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                Payload
//  -------   ---------  -----------------------  -------------------------------
//  s         in         i_s_tvalid / o_s_tready  tuser: mode; tdata: req_addr
//  m         out        o_m_tvalid / i_m_tready  tdata: result; tlast: last
//  cfg       in         i_cfg_valid / o_cfg_ready i_cfg_data: group_limit
//
//  For a join or quit, the word is taken in S_IDLE, and the parallel address
//  compare in the slot cells settles the answer in S_LOOK once the output is free.
//  A broadcast walks the scan token from the first cell up to the highest
//  occupied slot in use; the token steps one cell per cycle while not stalled.
//  A clear-all walks the token twice (a tally pass and then the listing pass),
//  with S_REST between them, so every listed word already carries the final count.
//  Reset clears the valid flags, the count and the token; the limit becomes 16.
//  A stalled result word holds the token in place and freezes the listing walk.
//
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module group_membership_table_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Request words.
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [gmt_pkg::ADDR_W-1:0]       i_s_tdata,   // [31:0] req_addr
    input  logic [gmt_pkg::MODE_W-1:0]       i_s_tuser,   // [1:0] mode
    // Result words.
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // [2:0] status, [6:3] slot, [38:7] member_addr, [43:39] member_count,
    // [47:44] zero fill
    output logic [gmt_pkg::OUT_DATA_W-1:0]   o_m_tdata,
    output logic                             o_m_tlast,
    // Group limit register.
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [gmt_pkg::CNT_W-1:0]        i_cfg_data
);
    import gmt_pkg::*;

    t_state              r_state, n_state;
    t_mode               r_mode;
    logic [ADDR_W-1:0]   r_key;
    logic [CNT_W-1:0]    r_limit;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [OCC_W-1:0]    r_acc, n_acc;

    // Output register, loaded only when the downstream slot is free.
    logic                r_out_valid;
    t_status             r_out_status, n_out_status;
    logic [SLOT_FLD_W-1:0] r_out_slot, n_out_slot;
    logic [ADDR_W-1:0]   r_out_addr, n_out_addr;
    logic [CNT_W-1:0]    r_out_count, n_out_count;
    logic                r_out_last, n_out_last;
    logic                out_load;
    logic                out_free;

    logic                accept;
    logic [CNT_W-1:0]    after_clear;
    t_row_cmd            row_cmd;
    t_row_stat           row_stat;

    gmt_row u_row (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (row_cmd),
        .o_stat  (row_stat)
    );

    assign o_s_tready  = (r_state == S_IDLE);
    assign accept      = i_s_tvalid & o_s_tready;
    assign o_cfg_ready = 1'b1;
    assign out_free    = ~r_out_valid | i_m_tready;

    // Count left after clearing the tallied members; it never drops below zero.
    assign after_clear = (SUB_W'(r_count) > SUB_W'(r_acc))
                       ? CNT_W'(SUB_W'(r_count) - SUB_W'(r_acc)) : '0;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tlast  = r_out_last;
    assign o_m_tdata  = {{OUT_PAD_W{1'b0}}, r_out_count, r_out_addr,
                         r_out_slot, r_out_status};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_limit     <= LIMIT_RST;
            r_count     <= '0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_acc   <= n_acc;
            if (i_cfg_valid && o_cfg_ready) begin
                r_limit <= i_cfg_data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode <= t_mode'(i_s_tuser);
            r_key  <= i_s_tdata;
        end
        if (out_load) begin
            r_out_status <= n_out_status;
            r_out_slot   <= n_out_slot;
            r_out_addr   <= n_out_addr;
            r_out_count  <= n_out_count;
            r_out_last   <= n_out_last;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_acc         = r_acc;
        row_cmd       = '0;
        row_cmd.key   = r_key;
        row_cmd.limit = r_limit;
        out_load      = 1'b0;
        n_out_status  = ST_EMPTY;
        n_out_slot    = '0;
        n_out_addr    = '0;
        n_out_count   = r_count;
        n_out_last    = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_LOOK;
                end
            end

            S_LOOK: begin
                unique case (r_mode)
                    MODE_JOIN: begin
                        if (out_free) begin
                            out_load = 1'b1;
                            n_state  = S_IDLE;
                            // Capacity is checked before duplicates.
                            priority if (SUB_W'(r_count) >= SUB_W'(r_limit)) begin
                                n_out_status = ST_FULL;
                            end else if (row_stat.any_hit) begin
                                n_out_status = ST_DUP;
                                n_out_slot   = SLOT_FLD_W'(row_stat.hit_idx);
                            end else if (row_stat.any_free) begin
                                n_out_status    = ST_JOINED;
                                n_out_slot      = SLOT_FLD_W'(row_stat.free_idx);
                                row_cmd.join_we = 1'b1;
                                n_count         = r_count + CNT_W'(1);
                            end else begin
                                // Room in the count but every slot in use is taken.
                                n_out_status = ST_FULL;
                            end
                            n_out_count = n_count;
                        end
                    end

                    MODE_QUIT: begin
                        if (out_free) begin
                            out_load = 1'b1;
                            n_state  = S_IDLE;
                            if (row_stat.any_hit) begin
                                n_out_status      = ST_REMOVED;
                                n_out_slot        = SLOT_FLD_W'(row_stat.hit_idx);
                                row_cmd.quit_kill = 1'b1;
                                if (r_count != '0) begin
                                    n_count = r_count - CNT_W'(1);
                                end
                            end else begin
                                n_out_status = ST_NOTMEM;
                            end
                            n_out_count = n_count;
                        end
                    end

                    MODE_LIST, MODE_CLEAR: begin
                        if (!row_stat.any_occ) begin
                            if (out_free) begin
                                out_load     = 1'b1;
                                n_out_status = ST_EMPTY;
                                n_state      = S_IDLE;
                            end
                        end else begin
                            // Launch the token into the first cell.
                            row_cmd.shift = 1'b1;
                            row_cmd.start = 1'b1;
                            n_acc         = '0;
                            n_state       = (r_mode == MODE_CLEAR) ? S_COUNT : S_SCAN;
                        end
                    end
                endcase
            end

            S_COUNT: begin
                // Tally pass: the token walks up to the last occupied slot.
                row_cmd.shift = 1'b1;
                if (row_stat.tok_occ) begin
                    n_acc = r_acc + OCC_W'(1);
                end
                if (row_stat.tok_last) begin
                    row_cmd.flush = 1'b1;
                    n_state       = S_REST;
                end
            end

            S_REST: begin
                n_count       = after_clear;
                row_cmd.shift = 1'b1;
                row_cmd.start = 1'b1;
                n_state       = S_SCAN;
            end

            S_SCAN: begin
                if (out_free) begin
                    row_cmd.shift      = 1'b1;
                    row_cmd.clear_scan = (r_mode == MODE_CLEAR);
                    if (row_stat.tok_occ) begin
                        out_load     = 1'b1;
                        n_out_status = ST_LISTED;
                        n_out_slot   = SLOT_FLD_W'(row_stat.tok_idx);
                        n_out_addr   = row_stat.tok_addr;
                        n_out_last   = row_stat.tok_last;
                    end
                    if (row_stat.tok_last) begin
                        row_cmd.flush = 1'b1;
                        n_state       = S_IDLE;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: design/gmt_checker.sv
// ----------------------------------------------------------------------------
// Group membership table port checker
// Watches the top-level ports for ordering and result-format slips.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "group_membership_table_unit_macros.svh"

module gmt_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_tvalid,
    input logic                            o_s_tready,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [gmt_pkg::OUT_DATA_W-1:0]  o_m_tdata,
    input logic                            o_m_tlast
);
    import gmt_pkg::*;

    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   member_addr;

    assign status      = o_m_tdata[OUT_STATUS_LSB +: STATUS_W];
    assign member_addr = o_m_tdata[OUT_ADDR_LSB +: ADDR_W];

    // One request at a time: a taken request word blocks the next cycle.
    `GMT_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready, "request taken while busy")

    // Only listing words can be followed by more words of the same request.
    `GMT_ASSERT_IMPL(a_single_is_last, i_clk, i_rst_n, o_m_tvalid && (status != ST_LISTED), o_m_tlast, "non-listing result not marked last")

    // Addresses are shown only on listing words.
    `GMT_ASSERT_IMPL(a_addr_zero, i_clk, i_rst_n, o_m_tvalid && (status != ST_LISTED), member_addr == '0, "address on a non-listing result")

    // A stalled result word is held unchanged.
    `GMT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast), "stalled result changed")

endmodule

bind group_membership_table_unit gmt_checker u_gmt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);

`default_nettype wire
